// ===== sv/dmsc_pkg.sv =====
// Shared codes, reset values and the rate table for the delta-modulation sample channel.
package dmsc_pkg;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_FETCH = 2'd2;

    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_LEVEL   = 3'd1;
    localparam logic [2:0] REG_ADDRESS = 3'd2;
    localparam logic [2:0] REG_LENGTH  = 3'd3;
    localparam logic [2:0] REG_ENABLE  = 3'd4;

    localparam logic [15:0] ADDR_RESET   = 16'hC000;
    localparam logic [15:0] ADDR_WRAP_LO = 16'h8000;
    localparam logic [15:0] ADDR_MAX     = 16'hFFFF;
    localparam logic [11:0] LEN_RESET    = 12'd1;
    localparam logic [7:0]  PERIOD_RESET = 8'd213;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
    localparam logic [6:0]  LEVEL_HIGH   = 7'd125;
    localparam logic [6:0]  LEVEL_LOW    = 7'd2;

    // Divider reload value: table entry minus one.
    function automatic logic [7:0] rate_period(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'd213;
            4'd1:    r = 8'd189;
            4'd2:    r = 8'd169;
            4'd3:    r = 8'd159;
            4'd4:    r = 8'd142;
            4'd5:    r = 8'd126;
            4'd6:    r = 8'd112;
            4'd7:    r = 8'd106;
            4'd8:    r = 8'd94;
            4'd9:    r = 8'd79;
            4'd10:   r = 8'd70;
            4'd11:   r = 8'd63;
            4'd12:   r = 8'd52;
            4'd13:   r = 8'd41;
            4'd14:   r = 8'd35;
            default: r = 8'd26;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/delta_modulation_sample_channel.sv =====
// Delta-modulation sample channel: state update and registered result stage.
//
// One item (register write, tick or returned sample byte) is taken per clock and
// produces exactly one result in the output register in the next cycle. The whole
// state update is a single combinational pass from the state registers, so the
// sustained rate is one item per cycle; only a stalled, still-full output
// register holds off the input side. A tick that requests a byte reports the
// address on fetch_addr with fetch_req set; the byte comes back later as a
// fetched-byte item and is dropped if no fetch is outstanding.
module delta_modulation_sample_channel
    import dmsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [2:0]  reg_select,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  level,
    output logic        irq,
    output logic        fetch_req,
    output logic [15:0] fetch_addr,
    output logic        active
);

    logic [6:0]  out_level_reg,     out_level_next;
    logic [7:0]  shifter_reg,       shifter_next;
    logic [3:0]  bits_left_reg,     bits_left_next;
    logic        silent_reg,        silent_next;
    logic [7:0]  buffer_byte_reg,   buffer_byte_next;
    logic        buffer_empty_reg,  buffer_empty_next;
    logic [11:0] bytes_left_reg,    bytes_left_next;
    logic [15:0] cur_addr_reg,      cur_addr_next;
    logic [15:0] start_addr_reg,    start_addr_next;
    logic [11:0] sample_len_reg,    sample_len_next;
    logic        loop_on_reg,       loop_on_next;
    logic        irq_enable_reg,    irq_enable_next;
    logic        irq_flag_reg,      irq_flag_next;
    logic        start_pending_reg, start_pending_next;
    logic [7:0]  rate_count_reg,    rate_count_next;
    logic [7:0]  rate_period_reg,   rate_period_next;
    logic        fetch_pending_reg, fetch_pending_next;

    logic        out_valid_reg,     out_valid_next;
    logic [6:0]  level_reg;
    logic        irq_reg;
    logic        fetch_req_reg;
    logic [15:0] fetch_addr_reg;
    logic        active_reg;

    logic        accept;
    logic        req;
    logic [15:0] req_addr;
    logic [3:0]  bits_dec;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign out_valid  = out_valid_reg;
    assign level      = level_reg;
    assign irq        = irq_reg;
    assign fetch_req  = fetch_req_reg;
    assign fetch_addr = fetch_addr_reg;
    assign active     = active_reg;

    always_comb
    begin
        out_level_next     = out_level_reg;
        shifter_next       = shifter_reg;
        bits_left_next     = bits_left_reg;
        silent_next        = silent_reg;
        buffer_byte_next   = buffer_byte_reg;
        buffer_empty_next  = buffer_empty_reg;
        bytes_left_next    = bytes_left_reg;
        cur_addr_next      = cur_addr_reg;
        start_addr_next    = start_addr_reg;
        sample_len_next    = sample_len_reg;
        loop_on_next       = loop_on_reg;
        irq_enable_next    = irq_enable_reg;
        irq_flag_next      = irq_flag_reg;
        start_pending_next = start_pending_reg;
        rate_count_next    = rate_count_reg;
        rate_period_next   = rate_period_reg;
        fetch_pending_next = fetch_pending_reg;
        req                = 1'b0;
        req_addr           = cur_addr_reg;
        bits_dec           = bits_left_reg - 4'd1;

        case (kind)
            KIND_WRITE:
            begin
                case (reg_select)
                    REG_CONTROL:
                    begin
                        irq_enable_next  = data[7];
                        loop_on_next     = data[6];
                        rate_period_next = rate_period(data[3:0]);
                        if (!data[7])
                        begin
                            irq_flag_next = 1'b0;
                        end
                    end
                    REG_LEVEL:   out_level_next  = data[6:0];
                    REG_ADDRESS: start_addr_next = {2'b11, data, 6'b0};
                    REG_LENGTH:  sample_len_next = {data, 4'b0001};
                    REG_ENABLE:
                    begin
                        if (data[4])
                        begin
                            start_pending_next = 1'b1;
                        end
                        else
                        begin
                            bytes_left_next = '0;
                        end
                        irq_flag_next = 1'b0;
                    end
                    default: ;
                endcase
            end

            KIND_TICK:
            begin
                if (start_pending_reg && bytes_left_reg == '0)
                begin
                    cur_addr_next   = start_addr_reg;
                    bytes_left_next = sample_len_reg;
                end

                if (buffer_empty_reg && bytes_left_next != '0 && !fetch_pending_reg)
                begin
                    req                = 1'b1;
                    req_addr           = cur_addr_next;
                    fetch_pending_next = 1'b1;
                    start_pending_next = 1'b0;
                    cur_addr_next      = (req_addr == ADDR_MAX) ? ADDR_WRAP_LO
                                                                : req_addr + 16'd1;
                    bytes_left_next    = bytes_left_next - 12'd1;
                    if (bytes_left_next == '0)
                    begin
                        if (loop_on_reg)
                        begin
                            cur_addr_next   = start_addr_reg;
                            bytes_left_next = sample_len_reg;
                        end
                        else if (irq_enable_reg)
                        begin
                            irq_flag_next = 1'b1;
                        end
                    end
                end

                if (rate_count_reg == '0)
                begin
                    rate_count_next = rate_period_reg;
                    if (!silent_reg)
                    begin
                        if (shifter_reg[0])
                        begin
                            if (out_level_reg <= LEVEL_HIGH)
                            begin
                                out_level_next = out_level_reg + 7'd2;
                            end
                        end
                        else if (out_level_reg >= LEVEL_LOW)
                        begin
                            out_level_next = out_level_reg - 7'd2;
                        end
                    end
                    shifter_next   = {1'b0, shifter_reg[7:1]};
                    bits_left_next = bits_dec;
                    if (bits_dec == '0)
                    begin
                        bits_left_next = BITS_PER_BYTE;
                        if (buffer_empty_reg)
                        begin
                            silent_next = 1'b1;
                        end
                        else
                        begin
                            shifter_next      = buffer_byte_reg;
                            buffer_empty_next = 1'b1;
                            silent_next       = 1'b0;
                        end
                    end
                end
                else
                begin
                    rate_count_next = rate_count_reg - 8'd1;
                end
            end

            KIND_FETCH:
            begin
                // a byte with no outstanding fetch is dropped
                if (fetch_pending_reg)
                begin
                    buffer_byte_next   = data;
                    buffer_empty_next  = 1'b0;
                    fetch_pending_next = 1'b0;
                end
            end

            default: ;
        endcase
    end

    assign out_valid_next = accept | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_level_reg     <= '0;
            shifter_reg       <= '0;
            bits_left_reg     <= BITS_PER_BYTE;
            silent_reg        <= 1'b1;
            buffer_byte_reg   <= '0;
            buffer_empty_reg  <= 1'b1;
            bytes_left_reg    <= '0;
            cur_addr_reg      <= ADDR_RESET;
            start_addr_reg    <= ADDR_RESET;
            sample_len_reg    <= LEN_RESET;
            loop_on_reg       <= 1'b0;
            irq_enable_reg    <= 1'b0;
            irq_flag_reg      <= 1'b0;
            start_pending_reg <= 1'b0;
            rate_count_reg    <= '0;
            rate_period_reg   <= PERIOD_RESET;
            fetch_pending_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                out_level_reg     <= out_level_next;
                shifter_reg       <= shifter_next;
                bits_left_reg     <= bits_left_next;
                silent_reg        <= silent_next;
                buffer_byte_reg   <= buffer_byte_next;
                buffer_empty_reg  <= buffer_empty_next;
                bytes_left_reg    <= bytes_left_next;
                cur_addr_reg      <= cur_addr_next;
                start_addr_reg    <= start_addr_next;
                sample_len_reg    <= sample_len_next;
                loop_on_reg       <= loop_on_next;
                irq_enable_reg    <= irq_enable_next;
                irq_flag_reg      <= irq_flag_next;
                start_pending_reg <= start_pending_next;
                rate_count_reg    <= rate_count_next;
                rate_period_reg   <= rate_period_next;
                fetch_pending_reg <= fetch_pending_next;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg      <= out_level_next;
            irq_reg        <= irq_flag_next;
            fetch_req_reg  <= req;
            fetch_addr_reg <= req ? req_addr : cur_addr_next;
            active_reg     <= (bytes_left_next != '0);
        end
    end

    // a fetch is only outstanding while the sample buffer is empty
    a_fetch_implies_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fetch_pending_reg |-> buffer_empty_reg)
        else $error("fetch outstanding with a full sample buffer");

    a_bits_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bits_left_reg != '0) && (bits_left_reg <= BITS_PER_BYTE))
        else $error("bit counter out of range");

    a_addr_upper_half: assert property (@(posedge clk) disable iff (!rst_n)
        cur_addr_reg[15] && start_addr_reg[15])
        else $error("sample address left the upper half");

    a_result_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> fetch_addr_reg[15])
        else $error("reported fetch address below the sample space");

    a_req_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req) |=> fetch_pending_reg && out_valid_reg && fetch_req_reg)
        else $error("request issued without marking the fetch outstanding");

endmodule
